### rtl/xvhe_pkg.sv
// Package for the XOR varint hex encoder: widths, key table and microcode ROM.
package xvhe_pkg;

    localparam int VALUE_W = 32;
    localparam int CH_W    = 7;
    localparam int POS_W   = 3;
    localparam int KEY_LEN = 7;

    localparam logic [CH_W-1:0]  CHAR_BASE = 7'd97;
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(KEY_LEN - 1);

    // One control word per microcode step
    typedef struct packed {
        logic form;     // build and key the next byte, emit its low nibble
        logic hi_nib;   // emit the stored high nibble
        logic end_chk;  // leave the program if this byte was the final one
        logic next;     // next step address
    } ucode_t;

    localparam logic STEP_LO = 1'b0;
    localparam logic STEP_HI = 1'b1;

    // Microcode ROM: two steps per keyed byte
    function automatic ucode_t ucode_rom(input logic step);
        ucode_t w;
        case (step)
            STEP_LO: w = '{form: 1'b1, hi_nib: 1'b0, end_chk: 1'b0, next: STEP_HI};
            STEP_HI: w = '{form: 1'b0, hi_nib: 1'b1, end_chk: 1'b1, next: STEP_LO};
            default: w = '{form: 1'b0, hi_nib: 1'b0, end_chk: 1'b0, next: STEP_LO};
        endcase
        return w;
    endfunction

    // Cyclic XOR key, indexed by byte position
    function automatic logic [7:0] key_byte(input logic [POS_W-1:0] pos);
        logic [7:0] k;
        case (pos)
            3'd0:    k = 8'h43;
            3'd1:    k = 8'h37;
            3'd2:    k = 8'h92;
            3'd3:    k = 8'ha4;
            3'd4:    k = 8'h38;
            3'd5:    k = 8'hf1;
            3'd6:    k = 8'h2b;
            default: k = 8'h00;
        endcase
        return k;
    endfunction

endpackage

### rtl/xor_varint_hex_encoder_unit.sv
// Record serializer: keyed LEB128 varint / raw byte writer with base-16 text output.
//
// Input channel (in_valid / in_stall): one item is func, value, start_req and
// end_of_record. func 0 writes value[7:0] as one byte, func 1 writes value as
// an unsigned LEB128 varint of one to five bytes. Each byte is XORed with a
// 7-byte key picked by its position in the record and sent as two characters,
// low nibble first, each nibble plus 'a'.
// Output channel (out_valid / out_stall): one item per character, with last on
// the final character of an input item and record_done on that character
// when the item carried end_of_record.
// Timing: a two-step microcode program runs once per byte, one character per
// step; a raw byte takes one run, a varint one to five runs. Once an item
// is accepted into the datapath registers, its first character enters the
// output register when the output slot is free. in_stall is high while the
// program runs and drops as the last character enters the output register;
// the next item can then be taken while that character waits. A new item is
// never taken before the program for the current one has ended.
// Reset clears the key position, the sequencer and the output valid flag. A
// stall on the output freezes the sequencer; the waiting character holds.
module xor_varint_hex_encoder_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        func,
    input  logic [xvhe_pkg::VALUE_W-1:0] value,
    input  logic                        start_req,
    input  logic                        end_of_record,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [xvhe_pkg::CH_W-1:0]   ch,
    output logic                        last,
    output logic                        record_done
);
    import xvhe_pkg::*;

    // Control state
    logic             busy_reg, busy_next;
    logic             step_reg, step_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             out_valid_reg, out_valid_next;

    // Datapath registers
    logic [VALUE_W-1:0] val_reg, val_next;
    logic               func_reg, func_next;
    logic               eor_reg, eor_next;
    logic [3:0]         hi_reg, hi_next;
    logic               final_reg, final_next;
    logic [CH_W-1:0]    ch_reg, ch_next;
    logic               last_reg, last_next;
    logic               done_reg, done_next;

    ucode_t     uw;
    logic       in_go;
    logic       slot_free;
    logic       emit_go;
    logic       more;
    logic [7:0] grp;
    logic [7:0] keyed;
    logic [3:0] nib;
    logic       exit_now;

    assign in_stall  = busy_reg;
    assign in_go     = in_valid && !busy_reg;
    assign slot_free = !out_valid_reg || !out_stall;
    assign emit_go   = busy_reg && slot_free;
    assign uw        = ucode_rom(step_reg);

    // Byte former: next varint group or raw byte, then keyed
    assign more  = |val_reg[VALUE_W-1:7];
    assign grp   = func_reg ? {more, val_reg[6:0]} : val_reg[7:0];
    assign keyed = grp ^ key_byte(pos_reg);
    assign nib   = uw.hi_nib ? hi_reg : keyed[3:0];
    assign exit_now = emit_go && uw.end_chk && final_reg;

    // Sequencer and datapath next values
    always_comb
    begin
        busy_next  = busy_reg;
        step_next  = step_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        func_next  = func_reg;
        eor_next   = eor_reg;
        hi_next    = hi_reg;
        final_next = final_reg;
        if (in_go)
        begin
            busy_next = 1'b1;
            step_next = STEP_LO;
            val_next  = value;
            func_next = func;
            eor_next  = end_of_record;
            if (start_req)
            begin
                pos_next = '0;
            end
        end
        else if (emit_go)
        begin
            step_next = uw.next;
            if (uw.form)
            begin
                hi_next    = keyed[7:4];
                final_next = !func_reg || !more;
                val_next   = {7'd0, val_reg[VALUE_W-1:7]};
                pos_next   = (pos_reg >= POS_LAST) ? '0 : pos_reg + 1'b1;
            end
            if (exit_now)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        ch_next        = ch_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        if (slot_free)
        begin
            out_valid_next = emit_go;
            if (emit_go)
            begin
                ch_next   = {3'd0, nib} + CHAR_BASE;
                last_next = uw.end_chk && final_reg;
                done_next = uw.end_chk && final_reg && eor_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_LO;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        func_reg  <= func_next;
        eor_reg   <= eor_next;
        hi_reg    <= hi_next;
        final_reg <= final_next;
        ch_reg    <= ch_next;
        last_reg  <= last_next;
        done_reg  <= done_next;
    end

    assign out_valid   = out_valid_reg;
    assign ch          = ch_reg;
    assign last        = last_reg;
    assign record_done = done_reg;

    // Checks
    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> step_reg == STEP_LO)
        else $error("sequencer idle away from first step");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != 3'd7)
        else $error("key position out of range");

    a_exit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        exit_now |=> !busy_reg && out_valid_reg && last_reg)
        else $error("program exit without last character");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_go |=> busy_reg && !out_valid_reg || busy_reg)
        else $error("accepted item did not start the program");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> last_reg)
        else $error("record_done without last");

endmodule
